// File: hw/rtl/mwuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_pkg
// Shared types, sizes and codes of the maze wall union-find block.
// ----------------------------------------------------------------------------
package mwuf_pkg;

    localparam int MAX_CELLS   = 4096;
    localparam int MAX_SIDE    = 64;
    localparam int CELL_W      = $clog2(MAX_CELLS);
    localparam int SIDE_W      = 7;
    localparam int WALL_W      = 13;
    localparam int POS_W       = WALL_W + 1;
    localparam int JOIN_W      = 13;
    localparam int AREA_W      = CELL_W + 1;
    localparam int RANK_W      = 4;
    localparam int EPOCH_W     = 8;
    localparam int DIV_CNT_W   = $clog2(POS_W);
    localparam int STACK_DEPTH = 16;
    localparam int STACK_W     = $clog2(STACK_DEPTH);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [RANK_W-1:0]    RANK_MAX    = '1;
    localparam logic [EPOCH_W-1:0]   EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0]   EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [SIDE_W-1:0]    SIDE_RESET  = SIDE_W'(8);
    localparam logic [SIDE_W-1:0]    SIDE_LIMIT  = SIDE_W'(MAX_SIDE);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic              new_maze;
        logic [WALL_W-1:0] wall_number;
    } t_in_word;

    typedef struct packed {
        logic [WALL_W-1:0] wall_echo;
        logic              carved;
        logic              complete;
        logic              bad_wall;
    } t_out_word;

    typedef struct packed {
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
    } t_size;

    // classified wall handed from front to back
    typedef struct packed {
        logic              new_maze;
        logic [WALL_W-1:0] wall;
        logic              bad;
        logic [CELL_W-1:0] cells_m1;
        logic [CELL_W-1:0] cell_a;
        logic [CELL_W-1:0] cell_b;
    } t_op;

    // set store entry: an entry whose tag differs from the live epoch is a fresh root
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [RANK_W-1:0]  rank;
        logic [CELL_W-1:0]  parent;
    } t_mem_word;

    // zero counts as one, anything above the side limit as the limit
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_LIMIT) begin
            r = SIDE_LIMIT;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/maze_wall_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_wall_union_find
// Kruskal maze carver core: maps shuffled walls to cell pairs and joins
// their sets in a union-find store with path compression and union by rank.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------------
//  in       | in        | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  out      | out       | o_out_valid / i_out_ready | o_out_word (t_out_word)
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  The front takes a word only when idle: size check, a 14-step divide for the cell
//  pair of a good wall, hand-over. The back goes straight to the result for a bad wall
//  or finished maze, else walks and compresses both root paths and joins, with a rank
//  update on a tie. Paths are at most 12 long; the back overlaps the front. A held result
//  stalls the back, and the front once the queue is full. After reset all 4096 store
//  entries are swept before a word is taken; the back sweeps again every 255th new maze.
// ----------------------------------------------------------------------------
module maze_wall_union_find (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mwuf_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mwuf_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mwuf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mwuf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [mwuf_pkg::SIDE_W-1:0] r_maze_width;
    logic [mwuf_pkg::SIDE_W-1:0] r_maze_height;
    mwuf_pkg::t_size             size;
    logic                        q_push_valid;
    logic                        q_push_ready;
    mwuf_pkg::t_op               q_push_op;
    logic                        q_pop_valid;
    logic                        q_pop_ready;
    mwuf_pkg::t_op               q_pop_op;
    logic                        clear_busy;

    assign o_cfg_ready = 1'b1;
    assign size.width  = r_maze_width;
    assign size.height = r_maze_height;

    // unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_width  <= mwuf_pkg::SIDE_RESET;
            r_maze_height <= mwuf_pkg::SIDE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mwuf_pkg::REG_MAZE_WIDTH) begin
                r_maze_width <= i_cfg_data;
            end else if (i_cfg_index == mwuf_pkg::REG_MAZE_HEIGHT) begin
                r_maze_height <= i_cfg_data;
            end
        end
    end

    mwuf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_size       (size),
        .i_clear_busy (clear_busy),
        .o_op_valid   (q_push_valid),
        .o_op         (q_push_op),
        .i_op_ready   (q_push_ready)
    );

    mwuf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_op    (q_push_op),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_op     (q_pop_op)
    );

    mwuf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (q_pop_valid),
        .o_op_ready   (q_pop_ready),
        .i_op         (q_pop_op),
        .o_clear_busy (clear_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

// File: hw/rtl/mwuf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_front
// Accepts wall words, checks them against the maze size and maps each in-range wall
// to the two cells it separates through a radix-2 divider.
// ----------------------------------------------------------------------------
module mwuf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mwuf_pkg::t_in_word i_in_word,
    input  mwuf_pkg::t_size    i_size,
    input  logic               i_clear_busy,
    output logic               o_op_valid,
    output mwuf_pkg::t_op      o_op,
    input  logic               i_op_ready
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SIZE,
        F_BOUND,
        F_DIV,
        F_CELL,
        F_PUSH
    } t_fstate;

    t_fstate                            r_state;
    logic                               r_new_maze;
    logic [mwuf_pkg::WALL_W-1:0]        r_wall;
    logic [mwuf_pkg::SIDE_W-1:0]        r_w;
    logic [mwuf_pkg::SIDE_W-1:0]        r_h;
    logic [mwuf_pkg::AREA_W-1:0]        r_wh;
    logic [mwuf_pkg::SIDE_W-1:0]        r_gw;
    logic [mwuf_pkg::POS_W-1:0]         r_dvd;
    logic [mwuf_pkg::SIDE_W-1:0]        r_rem;
    logic [mwuf_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                               r_bad;
    logic [mwuf_pkg::CELL_W-1:0]        r_cells_m1;
    logic [mwuf_pkg::CELL_W-1:0]        r_cell_a;
    logic [mwuf_pkg::CELL_W-1:0]        r_cell_b;

    logic [mwuf_pkg::POS_W-1:0]         wall_count;
    logic [mwuf_pkg::SIDE_W:0]          div_t;
    logic [mwuf_pkg::SIDE_W:0]          div_sub;
    logic                               div_ge;
    logic [mwuf_pkg::SIDE_W-1:0]        rem_next;
    logic                               col_zero;
    logic                               col_last;
    logic                               row_odd;
    logic [mwuf_pkg::POS_W:0]           row_a;
    logic [mwuf_pkg::POS_W:0]           row_b;
    logic [mwuf_pkg::SIDE_W-1:0]        col_a;
    logic [mwuf_pkg::SIDE_W-1:0]        col_b;
    logic [mwuf_pkg::POS_W+mwuf_pkg::SIDE_W:0] prod_a;
    logic [mwuf_pkg::POS_W+mwuf_pkg::SIDE_W:0] prod_b;
    logic [mwuf_pkg::POS_W:0]           sum_a;
    logic [mwuf_pkg::POS_W:0]           sum_b;

    assign o_in_ready = (r_state == F_IDLE) && !i_clear_busy;
    assign o_op_valid = (r_state == F_PUSH);

    assign o_op.new_maze = r_new_maze;
    assign o_op.wall     = r_wall;
    assign o_op.bad      = r_bad;
    assign o_op.cells_m1 = r_cells_m1;
    assign o_op.cell_a   = r_cell_a;
    assign o_op.cell_b   = r_cell_b;

    // 2*w*h - w - h walls in all
    assign wall_count = {r_wh, 1'b0} - mwuf_pkg::POS_W'(r_w) - mwuf_pkg::POS_W'(r_h);

    // restoring divide of the expanded-grid position by the grid row width
    assign div_t    = {r_rem, r_dvd[mwuf_pkg::POS_W-1]};
    assign div_ge   = div_t >= {1'b0, r_gw};
    assign div_sub  = div_t - {1'b0, r_gw};
    assign rem_next = div_ge ? div_sub[mwuf_pkg::SIDE_W-1:0] : div_t[mwuf_pkg::SIDE_W-1:0];

    // neighbours either side of the wall: row above/below on odd rows, left/right on even
    assign row_odd  = r_dvd[0];
    assign col_zero = (r_rem == '0);
    assign col_last = (r_rem == (r_gw - mwuf_pkg::SIDE_W'(1)));

    always_comb begin
        row_a = {1'b0, r_dvd};
        row_b = {1'b0, r_dvd};
        col_a = r_rem;
        col_b = r_rem;
        if (row_odd) begin
            row_a = {1'b0, r_dvd} - (mwuf_pkg::POS_W+1)'(1);
            row_b = {1'b0, r_dvd} + (mwuf_pkg::POS_W+1)'(1);
        end else begin
            if (col_zero) begin
                row_a = {1'b0, r_dvd} - (mwuf_pkg::POS_W+1)'(1);
                col_a = r_gw - mwuf_pkg::SIDE_W'(1);
            end else begin
                col_a = r_rem - mwuf_pkg::SIDE_W'(1);
            end
            if (col_last) begin
                row_b = {1'b0, r_dvd} + (mwuf_pkg::POS_W+1)'(1);
                col_b = '0;
            end else begin
                col_b = r_rem + mwuf_pkg::SIDE_W'(1);
            end
        end
    end

    assign prod_a = row_a * r_w;
    assign prod_b = row_b * r_w;
    assign sum_a  = prod_a[mwuf_pkg::POS_W:0] + (mwuf_pkg::POS_W+1)'(col_a);
    assign sum_b  = prod_b[mwuf_pkg::POS_W:0] + (mwuf_pkg::POS_W+1)'(col_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_new_maze <= i_in_word.new_maze;
                        r_wall     <= i_in_word.wall_number;
                        r_w        <= mwuf_pkg::clamp_side(i_size.width);
                        r_h        <= mwuf_pkg::clamp_side(i_size.height);
                        r_state    <= F_SIZE;
                    end
                end
                F_SIZE: begin
                    // both sides at most the limit, so the area never exceeds the store
                    r_wh    <= mwuf_pkg::AREA_W'(r_w) * mwuf_pkg::AREA_W'(r_h);
                    r_state <= F_BOUND;
                end
                F_BOUND: begin
                    r_bad      <= {1'b0, r_wall} >= wall_count;
                    r_cells_m1 <= mwuf_pkg::CELL_W'(r_wh - mwuf_pkg::AREA_W'(1));
                    r_gw       <= mwuf_pkg::SIDE_W'({r_w, 1'b0} - (mwuf_pkg::SIDE_W+1)'(1));
                    r_dvd      <= {r_wall, 1'b1};
                    r_rem      <= '0;
                    r_cnt      <= '0;
                    if ({1'b0, r_wall} >= wall_count) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_rem <= rem_next;
                    r_dvd <= {r_dvd[mwuf_pkg::POS_W-2:0], div_ge};
                    r_cnt <= r_cnt + mwuf_pkg::DIV_CNT_W'(1);
                    if (r_cnt == mwuf_pkg::DIV_CNT_W'(mwuf_pkg::POS_W - 1)) begin
                        r_state <= F_CELL;
                    end
                end
                F_CELL: begin
                    r_cell_a <= sum_a[mwuf_pkg::CELL_W:1];
                    r_cell_b <= sum_b[mwuf_pkg::CELL_W:1];
                    r_state  <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_op_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mwuf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_queue
// Short first-in first-out queue of classified walls between front and back.
// ----------------------------------------------------------------------------
module mwuf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  mwuf_pkg::t_op i_push_op,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output mwuf_pkg::t_op o_pop_op
);

    mwuf_pkg::t_op                 r_slot [mwuf_pkg::Q_DEPTH];
    logic [mwuf_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [mwuf_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [mwuf_pkg::Q_CNT_W-1:0]  r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_count != mwuf_pkg::Q_CNT_W'(mwuf_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                if (r_wr_ptr == mwuf_pkg::Q_PTR_W'(mwuf_pkg::Q_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + mwuf_pkg::Q_PTR_W'(1);
                end
            end
            if (pop) begin
                if (r_rd_ptr == mwuf_pkg::Q_PTR_W'(mwuf_pkg::Q_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + mwuf_pkg::Q_PTR_W'(1);
                end
            end
            if (push && !pop) begin
                r_count <= r_count + mwuf_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - mwuf_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/mwuf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_back
// Disjoint-set engine: two root searches with path compression, union by
// rank, join counting and the registered result word.
// ----------------------------------------------------------------------------
module mwuf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    output logic                o_op_ready,
    input  mwuf_pkg::t_op       i_op,
    output logic                o_clear_busy,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mwuf_pkg::t_out_word o_out_word
);

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_CLR,
        B_CHECK,
        B_FREAD,
        B_FCHK,
        B_COMP,
        B_FDONE,
        B_UNION,
        B_UNION2,
        B_OUT
    } t_bstate;

    // set store: parent, rank and epoch tag per cell
    mwuf_pkg::t_mem_word             mem [mwuf_pkg::MAX_CELLS];
    mwuf_pkg::t_mem_word             r_rd_data;

    t_bstate                         r_state;
    mwuf_pkg::t_op                   r_op;
    logic [mwuf_pkg::EPOCH_W-1:0]    r_epoch;
    logic [mwuf_pkg::CELL_W-1:0]     r_clr_cnt;
    logic [mwuf_pkg::JOIN_W-1:0]     r_joins;
    logic [mwuf_pkg::CELL_W-1:0]     r_cur;
    logic                            r_which;
    logic [mwuf_pkg::STACK_W-1:0]    r_sp;
    logic [mwuf_pkg::STACK_W-1:0]    r_idx;
    logic [mwuf_pkg::CELL_W-1:0]     r_stack_node [mwuf_pkg::STACK_DEPTH];
    logic [mwuf_pkg::RANK_W-1:0]     r_stack_rank [mwuf_pkg::STACK_DEPTH];
    logic [mwuf_pkg::CELL_W-1:0]     r_root;
    logic [mwuf_pkg::RANK_W-1:0]     r_root_rank;
    logic [mwuf_pkg::CELL_W-1:0]     r_x;
    logic [mwuf_pkg::RANK_W-1:0]     r_x_rank;
    logic                            r_carved;
    logic                            r_out_valid;
    mwuf_pkg::t_out_word             r_out_word;

    logic                            rd_live;
    logic [mwuf_pkg::CELL_W-1:0]     rd_parent;
    logic [mwuf_pkg::RANK_W-1:0]     rd_rank;
    logic [mwuf_pkg::CELL_W-1:0]     rd_addr;
    logic                            wr_en;
    logic [mwuf_pkg::CELL_W-1:0]     wr_addr;
    mwuf_pkg::t_mem_word             wr_data;
    logic [mwuf_pkg::RANK_W-1:0]     y_rank_inc;
    logic                            out_free;
    logic                            clr_last;

    assign o_op_ready   = (r_state == B_IDLE);
    assign o_clear_busy = (r_state == B_INIT);
    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign out_free     = !r_out_valid || i_out_ready;
    assign clr_last     = (r_clr_cnt == '1);

    // stale tag: the entry is untouched since the last new maze
    assign rd_live   = (r_rd_data.tag == r_epoch);
    assign rd_parent = rd_live ? r_rd_data.parent : r_cur;
    assign rd_rank   = rd_live ? r_rd_data.rank : '0;
    assign rd_addr   = (r_state == B_FCHK) ? rd_parent : r_cur;

    assign y_rank_inc = (r_root_rank == mwuf_pkg::RANK_MAX) ? r_root_rank
                      : r_root_rank + mwuf_pkg::RANK_W'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = '0;
        unique case (r_state)
            B_INIT, B_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_cnt;
            end
            B_COMP: begin
                wr_en   = 1'b1;
                wr_addr = r_stack_node[r_idx];
                wr_data = {r_epoch, r_stack_rank[r_idx], r_root};
            end
            B_UNION: begin
                wr_en = (r_x != r_root);
                if (r_x_rank > r_root_rank) begin
                    wr_addr = r_root;
                    wr_data = {r_epoch, r_root_rank, r_x};
                end else begin
                    wr_addr = r_x;
                    wr_data = {r_epoch, r_x_rank, r_root};
                end
            end
            B_UNION2: begin
                wr_en   = 1'b1;
                wr_addr = r_root;
                wr_data = {r_epoch, y_rank_inc, r_root};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_epoch     <= mwuf_pkg::EPOCH_FIRST;
            r_clr_cnt   <= '0;
            r_joins     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == B_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_INIT: begin
                    r_clr_cnt <= r_clr_cnt + mwuf_pkg::CELL_W'(1);
                    if (clr_last) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_op_valid) begin
                        r_op <= i_op;
                        if (i_op.new_maze) begin
                            r_joins <= mwuf_pkg::JOIN_W'(i_op.cells_m1);
                            // epoch about to wrap: sweep every tag back to zero
                            if (r_epoch == mwuf_pkg::EPOCH_MAX) begin
                                r_clr_cnt <= '0;
                                r_state   <= B_CLR;
                            end else begin
                                r_epoch <= r_epoch + mwuf_pkg::EPOCH_W'(1);
                                r_state <= B_CHECK;
                            end
                        end else begin
                            r_state <= B_CHECK;
                        end
                    end
                end
                B_CLR: begin
                    r_clr_cnt <= r_clr_cnt + mwuf_pkg::CELL_W'(1);
                    if (clr_last) begin
                        r_epoch <= mwuf_pkg::EPOCH_FIRST;
                        r_state <= B_CHECK;
                    end
                end
                B_CHECK: begin
                    r_carved <= 1'b0;
                    if (r_op.bad || (r_joins == '0)) begin
                        r_state <= B_OUT;
                    end else begin
                        r_cur   <= r_op.cell_a;
                        r_which <= 1'b0;
                        r_sp    <= '0;
                        r_state <= B_FREAD;
                    end
                end
                B_FREAD: begin
                    r_state <= B_FCHK;
                end
                B_FCHK: begin
                    if (rd_parent == r_cur) begin
                        r_root      <= r_cur;
                        r_root_rank <= rd_rank;
                        r_idx       <= '0;
                        if (r_sp == '0) begin
                            r_state <= B_FDONE;
                        end else begin
                            r_state <= B_COMP;
                        end
                    end else begin
                        // hold the node for compression, follow its parent
                        r_stack_node[r_sp] <= r_cur;
                        r_stack_rank[r_sp] <= rd_rank;
                        r_sp               <= r_sp + mwuf_pkg::STACK_W'(1);
                        r_cur              <= rd_parent;
                    end
                end
                B_COMP: begin
                    r_idx <= r_idx + mwuf_pkg::STACK_W'(1);
                    if (r_idx == (r_sp - mwuf_pkg::STACK_W'(1))) begin
                        r_state <= B_FDONE;
                    end
                end
                B_FDONE: begin
                    if (!r_which) begin
                        r_x      <= r_root;
                        r_x_rank <= r_root_rank;
                        r_which  <= 1'b1;
                        r_cur    <= r_op.cell_b;
                        r_sp     <= '0;
                        r_state  <= B_FREAD;
                    end else begin
                        r_state <= B_UNION;
                    end
                end
                B_UNION: begin
                    if (r_x == r_root) begin
                        r_state <= B_OUT;
                    end else begin
                        r_carved <= 1'b1;
                        r_joins  <= r_joins - mwuf_pkg::JOIN_W'(1);
                        if (r_x_rank == r_root_rank) begin
                            r_state <= B_UNION2;
                        end else begin
                            r_state <= B_OUT;
                        end
                    end
                end
                B_UNION2: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out_word.wall_echo <= r_op.wall;
                        r_out_word.carved    <= r_carved;
                        r_out_word.complete  <= (r_joins == '0);
                        r_out_word.bad_wall  <= r_op.bad;
                        r_state              <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/tb_maze_wall_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maze_wall_union_find
// Drives shuffled wall words into the maze carver over valid/ready, mirrors
// the disjoint-set store in a local union-find with path compression and
// union by rank, and checks every result word field by field. Directed walls
// at the size and wall-number extremes come first, then random mazes of many
// sizes with bad, repeated and restarting walls mixed in, under random stalls.
// ----------------------------------------------------------------------------
module tb_maze_wall_union_find;
    import mwuf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
    localparam int DRAIN_CYCLES  = 120;
    localparam int RANDOM_WALLS  = 500;
    localparam int MAZE_CAP      = 150;
    localparam int ROOT_LIMIT    = 8191;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_word              in_word;
    logic                  out_valid;
    logic                  out_ready;
    t_out_word             out_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // local copy of the set store and size registers
    logic [CELL_W-1:0] set_parent [MAX_CELLS];
    logic [RANK_W-1:0] set_rank [MAX_CELLS];
    int unsigned       joins_todo;
    logic [SIDE_W-1:0] cfg_width;
    logic [SIDE_W-1:0] cfg_height;

    t_in_word  walls_pending [$];
    t_out_word carve_awaited [$];
    int        n_queued;
    int        n_checked;
    int        err_count;

    bit tx_idle_on;
    bit rx_idle_on;
    int tx_gap;
    int rx_gap;
    int rx_hold;
    bit hold_done;

    maze_wall_union_find dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_sets();
        for (int k = 0; k < MAX_CELLS; k++) begin
            set_parent[k] = CELL_W'(k);
            set_rank[k]   = '0;
        end
    endfunction

    function automatic void eff_dims(input logic [SIDE_W-1:0] rw, input logic [SIDE_W-1:0] rh,
                                     output int unsigned w, output int unsigned h);
        w = rw;
        h = rh;
        if (w == 0) w = 1;
        if (w > MAX_SIDE) w = MAX_SIDE;
        if (h == 0) h = 1;
        if (h > MAX_SIDE) h = MAX_SIDE;
        if (w * h > MAX_CELLS) h = MAX_CELLS / w;
        if (h == 0) h = 1;
    endfunction

    function automatic int unsigned find_root(int unsigned x);
        int unsigned r;
        int unsigned steps;
        int unsigned nxt;
        r = x % MAX_CELLS;
        steps = 0;
        while (set_parent[r] != r && steps < MAX_CELLS) begin
            r = set_parent[r];
            steps++;
        end
        // compress the walked path onto the root
        x = x % MAX_CELLS;
        steps = 0;
        while (x != r && steps < MAX_CELLS) begin
            nxt = set_parent[x];
            set_parent[x] = CELL_W'(r);
            x = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic int unsigned cell_at(int unsigned pos, int unsigned grid_w,
                                            int unsigned w);
        return ((pos / grid_w) * w + (pos % grid_w)) >> 1;
    endfunction

    function automatic t_out_word kruskal_step(t_in_word iw);
        int unsigned w, h, cells, wcount, grid_w, wall, pos, p1, p2, x, y;
        t_out_word   r;
        eff_dims(cfg_width, cfg_height, w, h);
        cells = w * h;
        wall  = iw.wall_number;
        r = '0;
        r.wall_echo = iw.wall_number;
        if (iw.new_maze) begin
            clear_sets();
            joins_todo = (cells - 1 > ROOT_LIMIT) ? ROOT_LIMIT : cells - 1;
        end
        wcount = (w - 1) * h + w * (h - 1);
        grid_w = 2 * w - 1;
        if (wall >= wcount) begin
            r.bad_wall = 1'b1;
        end else if (joins_todo != 0) begin
            pos = 2 * wall + 1;
            if (((pos / grid_w) & 1) != 0) begin
                p1 = pos - grid_w;
                p2 = pos + grid_w;
            end else begin
                p1 = pos - 1;
                p2 = pos + 1;
            end
            x = find_root(cell_at(p1, grid_w, w));
            y = find_root(cell_at(p2, grid_w, w));
            if (x != y) begin
                if (set_rank[x] < set_rank[y]) begin
                    set_parent[x] = CELL_W'(y);
                end else if (set_rank[x] > set_rank[y]) begin
                    set_parent[y] = CELL_W'(x);
                end else begin
                    set_parent[x] = CELL_W'(y);
                    if (set_rank[y] < RANK_MAX) set_rank[y] = set_rank[y] + 1'b1;
                end
                joins_todo--;
                r.carved = 1'b1;
            end
        end
        r.complete = (joins_todo == 0);
        return r;
    endfunction

    // mostly none, sometimes short, rarely long
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_walls
        t_in_word nxt_word;
        logic     nxt_valid;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_word  = in_word;
            if (in_valid && in_ready) begin
                carve_awaited.push_back(kruskal_step(in_word));
                nxt_valid = 1'b0;
                tx_gap = pick_gap(tx_idle_on);
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (walls_pending.size() > 0) begin
                    nxt_word  = walls_pending.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
            in_word  <= nxt_word;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_results
        t_out_word want;
        logic      nxt_ready;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (carve_awaited.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected word, expected none, actual %p", $time, out_word);
                end else begin
                    want = carve_awaited.pop_front();
                    check_field("wall_echo", want.wall_echo, out_word.wall_echo);
                    check_field("carved", want.carved, out_word.carved);
                    check_field("complete", want.complete, out_word.complete);
                    check_field("bad_wall", want.bad_wall, out_word.bad_wall);
                    n_checked++;
                end
                rx_gap = pick_gap(rx_idle_on);
            end
            // one long hold-off while the sender still has plenty queued
            if (!hold_done && n_checked >= 80 && walls_pending.size() >= 10) begin
                hold_done = 1'b1;
                rx_hold = 600;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                nxt_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            out_ready <= nxt_ready;
        end
    end

    task automatic queue_wall(bit nm, logic [WALL_W-1:0] wall);
        t_in_word iw;
        iw.new_maze = nm;
        iw.wall_number = wall;
        walls_pending.push_back(iw);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_checked != n_queued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAZE_WIDTH: begin
                cfg_width = val;
            end
            REG_MAZE_HEIGHT: begin
                cfg_height = val;
            end
            default: begin
            end
        endcase
    endtask

    initial begin : stimulus
        int unsigned ew, eh, wcount, n_walls, j, tmp, rnd_items, r;
        int unsigned order [$];
        logic [SIDE_W-1:0] rw, rh;
        bit first_maze;
        bit nm;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        n_queued  = 0;
        n_checked = 0;
        err_count = 0;
        tx_gap    = 0;
        rx_gap    = 0;
        rx_hold   = 0;
        hold_done = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        clear_sets();
        joins_todo = 0;
        cfg_width  = SIDE_RESET;
        cfg_height = SIDE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default 8 x 8, counter still zero from reset
        queue_wall(1'b0, 13'd5);
        queue_wall(1'b0, 13'd8191);
        queue_wall(1'b1, 13'd0);
        queue_wall(1'b0, 13'd0);
        queue_wall(1'b0, 13'd111);
        queue_wall(1'b0, 13'd112);
        queue_wall(1'b1, 13'd8191);
        wait_idle();

        // zero width and oversized height clamp to one column of 64; spare indexes ignored
        write_reg(REG_MAZE_WIDTH, 7'd0);
        write_reg(REG_MAZE_HEIGHT, 7'd127);
        write_reg(REG_SPARE_A, 7'h7f);
        write_reg(REG_SPARE_B, 7'h00);
        queue_wall(1'b1, 13'd62);
        queue_wall(1'b0, 13'd0);
        queue_wall(1'b0, 13'd63);
        queue_wall(1'b0, 13'd31);
        wait_idle();

        // largest maze
        write_reg(REG_MAZE_WIDTH, 7'd127);
        write_reg(REG_MAZE_HEIGHT, 7'd64);
        queue_wall(1'b1, 13'd8063);
        queue_wall(1'b0, 13'd8064);
        queue_wall(1'b0, 13'd4096);
        queue_wall(1'b0, 13'd1);
        queue_wall(1'b0, 13'd126);
        wait_idle();

        // single cell: no walls at all
        write_reg(REG_MAZE_WIDTH, 7'd1);
        write_reg(REG_MAZE_HEIGHT, 7'd1);
        queue_wall(1'b1, 13'd0);
        queue_wall(1'b0, 13'd0);
        wait_idle();

        // resize mid maze, then run past completion
        write_reg(REG_MAZE_WIDTH, 7'd2);
        write_reg(REG_MAZE_HEIGHT, 7'd2);
        queue_wall(1'b1, 13'd0);
        queue_wall(1'b0, 13'd1);
        wait_idle();
        write_reg(REG_MAZE_WIDTH, 7'd3);
        queue_wall(1'b0, 13'd4);
        queue_wall(1'b0, 13'd6);
        queue_wall(1'b0, 13'd2);
        queue_wall(1'b0, 13'd5);
        wait_idle();

        rnd_items  = 0;
        first_maze = 1'b1;
        while (rnd_items < RANDOM_WALLS) begin
            r = $urandom_range(99);
            if (first_maze) begin
                rw = 7'd12;
                rh = 7'd12;
            end else if (r < 70) begin
                rw = SIDE_W'($urandom_range(6, 1));
                rh = SIDE_W'($urandom_range(6, 1));
            end else if (r < 90) begin
                rw = SIDE_W'($urandom_range(16, 7));
                rh = SIDE_W'($urandom_range(16, 7));
            end else begin
                rw = SIDE_W'($urandom_range(127, 0));
                rh = SIDE_W'($urandom_range(127, 0));
            end
            write_reg(REG_MAZE_WIDTH, rw);
            write_reg(REG_MAZE_HEIGHT, rh);
            if ($urandom_range(9) == 0) begin
                write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                          SIDE_W'($urandom_range(127, 0)));
            end
            tx_idle_on = ($urandom_range(3) != 0);
            rx_idle_on = ($urandom_range(3) != 0);

            eff_dims(rw, rh, ew, eh);
            wcount = (ew - 1) * eh + ew * (eh - 1);
            order = {};
            for (int unsigned k = 0; k < wcount; k++) order.push_back(k);
            for (int unsigned k = wcount; k > 1; k--) begin
                j = $urandom_range(k - 1, 0);
                tmp = order[k - 1];
                order[k - 1] = order[j];
                order[j] = tmp;
            end
            n_walls = (wcount > MAZE_CAP) ? MAZE_CAP : wcount;
            // a few mazes carry on from the previous store under the new size
            nm = (first_maze || $urandom_range(9) != 0);
            if (n_walls == 0) begin
                queue_wall(nm, WALL_W'($urandom_range(8191, 0)));
            end
            for (int unsigned k = 0; k < n_walls; k++) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    queue_wall(1'b0, WALL_W'($urandom_range(8191, wcount)));
                end else if (r < 13 && k > 0) begin
                    queue_wall(1'b0, WALL_W'(order[$urandom_range(k - 1, 0)]));
                    rnd_items++;
                end
                queue_wall(nm || ($urandom_range(99) < 2), WALL_W'(order[k]));
                nm = 1'b0;
                rnd_items++;
            end
            // walls after completion are not examined
            if (wcount > 0 && wcount <= MAZE_CAP) begin
                queue_wall(1'b0, WALL_W'(order[0]));
                rnd_items++;
            end
            first_maze = 1'b0;
            wait_idle();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mwuf_pkg.sv
hw/rtl/mwuf_front.sv
hw/rtl/mwuf_queue.sv
hw/rtl/mwuf_back.sv
hw/rtl/maze_wall_union_find.sv
tb/tb_maze_wall_union_find.sv
